// ===== design/tcg_pkg.sv =====
// ----------------------------------------------------------------------------
// tcg_pkg
// Shared constants and types for the timed curve generator.
// ----------------------------------------------------------------------------
package tcg_pkg;

    // Parameter defaults
    localparam int TIME_BITS_DEF    = 16;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int BREATH_DEPTH_DEF = 256;

    // Fixed field widths
    localparam int STEP_W      = 16;
    localparam int TIMEOUT_W   = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 24;

    // Register map
    localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_REPEAT  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CURVE   = 2'd2;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd1000;

    typedef enum logic [1:0] {
        CURVE_TOGGLE = 2'd0,
        CURVE_LINEAR = 2'd1,
        CURVE_SQUARE = 2'd2,
        CURVE_BREATH = 2'd3
    } t_curve;

endpackage

// ===== design/tcg_serial_div.sv =====
// ----------------------------------------------------------------------------
// tcg_serial_div
// Restoring divider, one quotient bit per cycle: quot = (num << FRAC) / den.
// Requires num < den, so the quotient fits in FRAC_BITS bits.
// ----------------------------------------------------------------------------
module tcg_serial_div #(
    parameter int TIME_BITS = tcg_pkg::TIME_BITS_DEF,
    parameter int FRAC_BITS = tcg_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [TIME_BITS-1:0] i_num,
    input  logic [TIME_BITS-1:0] i_den,
    output logic                 o_done,
    output logic [FRAC_BITS-1:0] o_quot
);
    localparam int CW = $clog2(FRAC_BITS + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [TIME_BITS-1:0] r_rem;
    logic [TIME_BITS-1:0] r_den;
    logic [FRAC_BITS-1:0] r_quot;

    logic [TIME_BITS:0]   w_shift;
    logic [TIME_BITS:0]   w_diff;
    logic                 w_ge;
    logic [TIME_BITS-1:0] n_rem;

    assign w_shift = {r_rem, 1'b0};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign n_rem   = w_ge ? w_diff[TIME_BITS-1:0] : w_shift[TIME_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(FRAC_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[FRAC_BITS-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== design/tcg_breath_rom.sv =====
// ----------------------------------------------------------------------------
// tcg_breath_rom
// Breathing curve table, exp(-((x-0.5)/0.2)^2/2) in Q1.FRAC, registered read.
// Contents are built at elaboration from a truncated series raised to 2^8.
// ----------------------------------------------------------------------------
module tcg_breath_rom #(
    parameter int FRAC_BITS = tcg_pkg::FRAC_BITS_DEF,
    parameter int DEPTH     = tcg_pkg::BREATH_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic [$clog2(DEPTH)-1:0]   i_addr,
    output logic [FRAC_BITS:0]         o_data
);
    localparam longint unsigned M_LAST = longint'(DEPTH - 1);
    localparam longint unsigned M_SQ   = M_LAST * M_LAST;
    localparam longint unsigned Q30    = 64'd1 << 30;
    localparam longint unsigned RND29  = 64'd1 << 29;
    localparam longint unsigned RND_OUT = 64'd1 << (29 - FRAC_BITS);

    function automatic logic [FRAC_BITS:0] breath_entry(input longint unsigned k);
        longint unsigned n;
        longint unsigned s;
        longint unsigned s2;
        longint unsigned s3;
        longint unsigned v;
        n  = (2 * k >= M_LAST) ? (2 * k - M_LAST) : (M_LAST - 2 * k);
        s  = ((64'd25 * n * n) << 19) / M_SQ;
        s2 = (s * s) >> 30;
        s3 = (s2 * s) >> 30;
        v  = Q30 - s + (s2 >> 1) - s3 / 6;
        for (int i = 0; i < 8; i++) begin
            v = (v * v + RND29) >> 30;
        end
        return (FRAC_BITS + 1)'((v + RND_OUT) >> (30 - FRAC_BITS));
    endfunction

    logic [FRAC_BITS:0] w_rom [DEPTH];
    logic [FRAC_BITS:0] r_data;

    for (genvar k = 0; k < DEPTH; k++) begin : g_rom
        localparam logic [FRAC_BITS:0] ENTRY = breath_entry(longint'(k));
        assign w_rom[k] = ENTRY;
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_rom[i_addr];
    end

    assign o_data = r_data;

endmodule

// ===== design/timed_curve_generator.sv =====
// ----------------------------------------------------------------------------
// timed_curve_generator
// Timed ramp: elapsed-time counter, progress by serial division, curve shaper.
// ----------------------------------------------------------------------------
// Usage
//   Slave stream: one beat per tick. tdata[0] = enable, tdata[16:1] = step_ms.
//   Master stream: one beat per tick, tdata[FRAC_BITS:0] = level (Q1.FRAC).
//   Config port: i_cfg_we / i_cfg_addr / i_cfg_wdata, write-only, no wait.
//     0 timeout_ms, 1 repeat_mode, 2 curve_kind. Write only while idle.
// Path (accept to master tvalid)
//   When a division runs: S_DIV, S_SHAPE, S_PICK, S_DONE, then the output
//   register; the serial divider makes one progress bit per cycle.
//   At or beyond the timeout S_DIV is skipped; with enable low the beat
//   goes straight from S_IDLE to S_DONE.
// Intake: a new tick beat is taken only in S_IDLE, after the last one leaves S_DONE.
// Reset: synchronous, active low; registers go to timeout 1000, hold mode,
//   toggle curve, counter zero, no beat pending.
// Stall: the result sits in an output register; a new beat is still taken
//   while it waits, and the sequencer holds its finished level until the
//   output register frees up.
// ----------------------------------------------------------------------------
module timed_curve_generator #(
    parameter int TIME_BITS          = tcg_pkg::TIME_BITS_DEF,
    parameter int FRAC_BITS          = tcg_pkg::FRAC_BITS_DEF,
    parameter int BREATH_TABLE_DEPTH = tcg_pkg::BREATH_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [tcg_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [tcg_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // tick stream in
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [tcg_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // enable, step_ms, pad
    // level stream out
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [((FRAC_BITS+8)/8)*8-1:0]    m_axis_tdata   // level, pad
);
    import tcg_pkg::*;

    localparam int OUT_W = ((FRAC_BITS + 8) / 8) * 8;
    localparam int AW    = $clog2(BREATH_TABLE_DEPTH);
    localparam int IW    = FRAC_BITS + AW + 2;   // index product width
    localparam int SW    = 2 * FRAC_BITS + 1;    // square width
    localparam logic [FRAC_BITS:0] P_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [AW+1:0]      IDX_MAX = (AW + 2)'(BREATH_TABLE_DEPTH - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_SHAPE = 5'b00100,
        S_PICK  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // config registers
    logic [TIMEOUT_W-1:0] r_timeout_ms;
    logic                 r_repeat_mode;
    t_curve               r_curve_kind;

    // sequencer and datapath
    t_state               r_state, n_state;
    logic [TIME_BITS-1:0] r_elapsed;
    logic [TIME_BITS-1:0] r_cnt;
    logic                 r_en;
    logic [FRAC_BITS:0]   r_p;
    logic [SW-1:0]        r_sq;
    logic [AW-1:0]        r_idx;
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out_data;

    logic                 w_in_acc;
    logic                 w_en;
    logic [TIME_BITS-1:0] w_step;
    logic [TIME_BITS-1:0] w_tmo;
    logic [TIME_BITS:0]   w_sum;
    logic [TIME_BITS-1:0] n_cnt;
    logic                 w_sat;
    logic                 w_div_start;
    logic                 w_div_done;
    logic [FRAC_BITS-1:0] w_quot;
    logic [IW-1:0]        w_idx_prod;
    logic [AW+1:0]        w_idx_full;
    logic [AW-1:0]        n_idx;
    logic [SW-1:0]        w_sq_rnd;
    logic                 w_toggle;
    logic [FRAC_BITS:0]   w_rom_data;
    logic [FRAC_BITS:0]   n_level;
    logic                 w_out_free;

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ms  <= TIMEOUT_RST;
            r_repeat_mode <= 1'b0;
            r_curve_kind  <= CURVE_TOGGLE;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == REG_TIMEOUT) begin
                r_timeout_ms <= i_cfg_wdata;
            end
            if (i_cfg_addr == REG_REPEAT) begin
                r_repeat_mode <= i_cfg_wdata[0];
            end
            if (i_cfg_addr == REG_CURVE) begin
                r_curve_kind <= t_curve'(i_cfg_wdata[1:0]);
            end
        end
    end

    // ---- tick intake: counter update, wrap or hold ----
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_en          = s_axis_tdata[0];
    assign w_step        = TIME_BITS'(s_axis_tdata[STEP_W:1]);
    assign w_tmo         = TIME_BITS'(r_timeout_ms);
    assign w_sum         = (TIME_BITS + 1)'(r_elapsed) + (TIME_BITS + 1)'(w_step);

    always_comb begin
        if (w_sum > {1'b0, w_tmo}) begin
            n_cnt = r_repeat_mode ? '0 : w_tmo;
        end else begin
            n_cnt = w_sum[TIME_BITS-1:0];
        end
    end

    // progress saturates at 1.0 at or past the timeout (also zero timeout)
    assign w_sat       = (w_tmo == '0) || (n_cnt >= w_tmo);
    assign w_div_start = w_in_acc && w_en && !w_sat;

    tcg_serial_div #(
        .TIME_BITS (TIME_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (n_cnt),
        .i_den   (w_tmo),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // ---- shaping ----
    assign w_idx_prod = IW'(r_p) * IW'(BREATH_TABLE_DEPTH - 1)
                      + IW'(P_ONE >> 1);
    assign w_idx_full = w_idx_prod[IW-1:FRAC_BITS];
    assign n_idx      = (w_idx_full > IDX_MAX) ? IDX_MAX[AW-1:0] : w_idx_full[AW-1:0];

    tcg_breath_rom #(
        .FRAC_BITS (FRAC_BITS),
        .DEPTH     (BREATH_TABLE_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (r_idx),
        .o_data (w_rom_data)
    );

    assign w_sq_rnd = r_sq + SW'(P_ONE >> 1);
    assign w_toggle = {r_cnt, 1'b0} > {1'b0, w_tmo};

    always_comb begin
        if (!r_en) begin
            n_level = '0;
        end else begin
            unique case (r_curve_kind)
                CURVE_TOGGLE: n_level = w_toggle ? P_ONE : '0;
                CURVE_LINEAR: n_level = r_p;
                CURVE_SQUARE: n_level = w_sq_rnd[2*FRAC_BITS:FRAC_BITS];
                CURVE_BREATH: n_level = w_rom_data;
                default:      n_level = '0;
            endcase
        end
    end

    assign w_out_free = !r_out_valid || m_axis_tready;

    // ---- sequencer ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (!w_en) begin
                        n_state = S_DONE;
                    end else if (w_sat) begin
                        n_state = S_SHAPE;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV:   if (w_div_done) n_state = S_SHAPE;
            S_SHAPE: n_state = S_PICK;
            S_PICK:  n_state = S_DONE;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_elapsed <= w_en ? n_cnt : '0;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_en  <= w_en;
            r_cnt <= n_cnt;
            r_p   <= P_ONE;
        end
        if (r_state == S_DIV && w_div_done) begin
            r_p <= {1'b0, w_quot};
        end
        if (r_state == S_SHAPE) begin
            r_sq  <= SW'(r_p) * SW'(r_p);
            r_idx <= n_idx;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out_data <= OUT_W'(n_level);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== design/tcg_checker.sv =====
// ----------------------------------------------------------------------------
// tcg_checker
// Port-level checks on the timed curve generator, bound to the top level.
// ----------------------------------------------------------------------------
module tcg_checker #(
    parameter int FRAC_BITS = tcg_pkg::FRAC_BITS_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           i_s_tready,
    input logic                           i_m_tvalid,
    input logic                           i_m_tready,
    input logic [((FRAC_BITS+8)/8)*8-1:0] i_m_tdata
);
    localparam int OUT_W = ((FRAC_BITS + 8) / 8) * 8;
    localparam logic [OUT_W-1:0] LEVEL_ONE = {{(OUT_W-1){1'b0}}, 1'b1} << FRAC_BITS;

    // a pending beat holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("output beat changed while stalled");

    // level never exceeds 1.0
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> i_m_tdata <= LEVEL_ONE)
        else $error("level above 1.0");

    // one tick at a time: intake closes after a beat is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("second tick taken while busy");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("output valid after reset");

endmodule

bind timed_curve_generator tcg_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_tcg_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

// ===== tb/sv/tb_timed_curve_generator.sv =====
// ----------------------------------------------------------------------------
// tb_timed_curve_generator
// Self-checking bench for the timed curve generator. A local model keeps its
// own copy of the registers and of the elapsed counter and works out the
// level for every tick beat taken. The level stream is checked beat by beat
// against that model. Both stream sides idle at random, and one stretch holds
// the level stream off long enough to stall the tick input.
// ----------------------------------------------------------------------------
module tb_timed_curve_generator;
    import tcg_pkg::*;

    localparam int                     CYCLE_LIMIT = 200000;
    localparam int                     LEVEL_W     = FRAC_BITS_DEF + 1;
    localparam int                     LUT_DEPTH   = BREATH_DEPTH_DEF;
    localparam longint unsigned        ONE_Q       = 64'd1 << FRAC_BITS_DEF;
    localparam longint unsigned        HALF_Q      = 64'd1 << (FRAC_BITS_DEF - 1);
    // index 3 lies outside the register map; writes to it must be dropped
    localparam logic [CFG_ADDR_W-1:0]  REG_UNUSED  = 2'd3;

    // DUT drive, all known from time zero
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [0] enable, [16:1] step_ms, pad
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [23:0]            m_axis_tdata;         // [16:0] level, pad

    // model state: registers as the block should hold them, plus the counter
    logic [TIMEOUT_W-1:0]   tmo_r     = TIMEOUT_RST;
    logic                   wrap_r    = 1'b0;
    t_curve                 shape_r   = CURVE_TOGGLE;
    logic [15:0]            elapsed_r = '0;
    logic [LEVEL_W-1:0]     breath_lut [LUT_DEPTH];

    logic [LEVEL_W-1:0]     level_q [$];   // levels still owed by the block
    int                     err_count   = 0;
    int                     cycle_count = 0;
    bit                     tx_idle     = 1'b1;   // sender draws gaps
    bit                     rx_idle     = 1'b1;   // receiver draws stalls
    int                     rx_hold_req = 0;      // one long hold-off, in cycles

    timed_curve_generator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Breathing table, built by the same integer series as the ROM:
    // 1 - s + s^2/2 - s^3/6 approximates exp(-t/256), then eight squarings.
    initial begin : breath_lut_build
        longint unsigned m, n, s, s2, s3, v;
        int k;
        m = LUT_DEPTH - 1;
        for (k = 0; k < LUT_DEPTH; k++) begin
            n  = (2 * k >= m) ? (2 * k - m) : (m - 2 * k);
            s  = ((64'd25 * n * n) << 19) / (m * m);
            s2 = (s * s) >> 30;
            s3 = (s2 * s) >> 30;
            v  = (64'd1 << 30) - s + (s2 >> 1) - s3 / 6;
            repeat (8) v = (v * v + (64'd1 << 29)) >> 30;
            breath_lut[k] = LEVEL_W'((v + (64'd1 << (29 - FRAC_BITS_DEF))) >> (30 - FRAC_BITS_DEF));
        end
    end

    // Advance the model by one tick and return the level it should produce.
    function automatic logic [LEVEL_W-1:0] predict_level(input bit en,
                                                         input logic [15:0] step);
        longint unsigned cnt, tmo, prog, idx, lvl;
        if (!en) begin
            elapsed_r = '0;
            return '0;
        end
        tmo = tmo_r;
        cnt = longint'(elapsed_r) + step;
        if (cnt > tmo)
            cnt = wrap_r ? 0 : tmo;
        elapsed_r = cnt[15:0];
        // zero timeout and a counter at the timeout both read as full progress
        if (tmo == 0 || cnt >= tmo)
            prog = ONE_Q;
        else
            prog = (cnt << FRAC_BITS_DEF) / tmo;
        case (shape_r)
            CURVE_TOGGLE: lvl = (2 * cnt > tmo) ? ONE_Q : 0;
            CURVE_LINEAR: lvl = prog;
            CURVE_SQUARE: lvl = (prog * prog + HALF_Q) >> FRAC_BITS_DEF;
            default: begin
                idx = (prog * (LUT_DEPTH - 1) + HALF_Q) >> FRAC_BITS_DEF;
                if (idx > LUT_DEPTH - 1)
                    idx = LUT_DEPTH - 1;
                lvl = breath_lut[idx];
            end
        endcase
        return LEVEL_W'(lvl);
    endfunction

    // One register write; the model follows at the edge that takes it.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (addr)
            REG_TIMEOUT: tmo_r   = data;
            REG_REPEAT:  wrap_r  = data[0];
            REG_CURVE:   shape_r = t_curve'(data[1:0]);
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one tick beat, after a random gap when the sender idles.
    // tvalid stays up on return so back-to-back beats need no drop.
    task automatic send_tick(input bit en, input logic [15:0] step);
        int gap;
        gap = tx_idle ? $urandom_range(0, 10) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - 17){1'b0}}, step, en};
        do @(posedge i_clk); while (!s_axis_tready);
        level_q.push_back(predict_level(en, step));
    endtask

    // Drop tvalid and wait until every owed level has come out.
    task automatic settle();
        if (s_axis_tvalid)
            s_axis_tvalid <= 1'b0;
        while (level_q.size() != 0) @(posedge i_clk);
    endtask

    // Reset values: timeout 1000, hold, toggle. Half-way exactly is not
    // above half, so 500 ms reads 0 and 501 ms reads 1.0.
    task automatic test_reset_defaults();
        send_tick(1'b0, 16'hFFFF);
        send_tick(1'b1, 16'd500);
        send_tick(1'b1, 16'd1);
        send_tick(1'b1, 16'hFFFF);    // overshoot, holds at the timeout
        send_tick(1'b0, 16'd0);
        settle();
    endtask

    // A write to the spare index must leave all registers alone.
    task automatic test_unused_index();
        write_reg(REG_UNUSED, 16'h0001);
        send_tick(1'b1, 16'd250);
        settle();
    endtask

    // Each curve at full-scale timeout: cleared, just under half, just over
    // half, then an overshoot. Junk in the upper bits of repeat must be masked.
    task automatic test_curve_shapes();
        int c;
        write_reg(REG_TIMEOUT, 16'hFFFF);
        write_reg(REG_REPEAT, 16'hFFFE);
        for (c = 0; c < 4; c++) begin
            settle();
            write_reg(REG_CURVE, CFG_DATA_W'(16'hFFFC | c));
            send_tick(1'b0, 16'd0);
            send_tick(1'b1, 16'd32767);
            send_tick(1'b1, 16'd1);
            send_tick(1'b1, 16'hFFFF);
        end
        settle();
    endtask

    // Smallest timeout with wrap, the zero timeout the port still allows,
    // and a timeout lowered beneath a running counter.
    task automatic test_edge_timeouts();
        write_reg(REG_TIMEOUT, 16'd1);
        write_reg(REG_REPEAT, 16'hAAAB);
        write_reg(REG_CURVE, CFG_DATA_W'(CURVE_SQUARE));
        send_tick(1'b1, 16'd1);
        send_tick(1'b1, 16'd1);       // past the timeout, wraps to zero
        settle();
        write_reg(REG_TIMEOUT, 16'd0);
        write_reg(REG_CURVE, CFG_DATA_W'(CURVE_BREATH));
        send_tick(1'b1, 16'd7);
        send_tick(1'b1, 16'd0);
        settle();
        write_reg(REG_TIMEOUT, 16'hFFFF);
        write_reg(REG_REPEAT, 16'd0);
        write_reg(REG_CURVE, CFG_DATA_W'(CURVE_LINEAR));
        send_tick(1'b1, 16'd40000);
        settle();
        write_reg(REG_TIMEOUT, 16'd1000);
        send_tick(1'b1, 16'd0);       // counter now above the timeout
        settle();
    endtask

    // Runs of mostly enabled ticks with steps scaled to the timeout, so the
    // counter sweeps the whole curve and crosses the timeout often. Phases
    // pair each timeout class with each curve; some phases run without gaps.
    task automatic test_random_runs();
        int phase, k, sel;
        logic [15:0] tmo, step;
        bit en;
        for (phase = 0; phase < 16; phase++) begin
            case (phase % 4)
                0:       tmo = 16'($urandom_range(1, 24));
                1:       tmo = 16'($urandom_range(1, 65535));
                2:       tmo = (phase < 8) ? 16'd1 : 16'hFFFF;
                default: tmo = 16'($urandom_range(100, 3000));
            endcase
            tx_idle = (phase % 5) != 2;
            rx_idle = (phase % 3) != 1;
            settle();
            write_reg(REG_TIMEOUT, tmo);
            write_reg(REG_REPEAT, 16'($urandom));
            write_reg(REG_CURVE,
                      CFG_DATA_W'(($urandom & 16'hFFFC) | ((phase + phase / 4) % 4)));
            for (k = 0; k < 40; k++) begin
                en  = $urandom_range(0, 19) != 0;
                sel = $urandom_range(0, 9);
                case (sel)
                    0:       step = 16'($urandom);
                    1:       step = 16'd0;
                    default: step = 16'($urandom_range(0, tmo / 6 + 1));
                endcase
                send_tick(en, step);
            end
        end
        settle();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // Level stream held off for a long stretch while ticks keep coming:
    // the output register and the sequencer fill, then tready must drop.
    task automatic test_output_stall();
        int k;
        write_reg(REG_CURVE, CFG_DATA_W'(CURVE_BREATH));
        tx_idle     = 1'b0;
        rx_hold_req = 400;
        for (k = 0; k < 24; k++)
            send_tick(1'b1, 16'($urandom_range(0, 200)));
        settle();
        tx_idle = 1'b1;
    endtask

    // Level sink: random stall per beat, plus the long hold-off on request.
    initial begin : level_sink
        int stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (rx_hold_req != 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_req) @(posedge i_clk);
                rx_hold_req = 0;
            end
            stall = rx_idle ? $urandom_range(0, 10) : 0;
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Level checker: every beat taken must match the oldest owed level.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (level_q.size() == 0) begin
                $display("%0t: level beat with none owed, got %0d",
                         $time, m_axis_tdata[LEVEL_W-1:0]);
                err_count++;
            end else if (m_axis_tdata[LEVEL_W-1:0] !== level_q[0]) begin
                $display("%0t: level mismatch, expected %0d got %0d",
                         $time, level_q[0], m_axis_tdata[LEVEL_W-1:0]);
                err_count++;
                void'(level_q.pop_front());
            end else begin
                void'(level_q.pop_front());
            end
        end
    end

    // Watchdog: a hang or a lost beat ends the run here.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_timed_curve_generator: errors");
        $finish;
    end

    initial begin : run
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_unused_index();
        test_curve_shapes();
        test_edge_timeouts();
        test_random_runs();
        test_output_stall();
        settle();
        // a little slack so any stray extra beat still gets caught
        repeat (40) @(posedge i_clk);
        if (err_count == 0)
            $display("tb_timed_curve_generator: clean");
        else
            $display("tb_timed_curve_generator: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
design/tcg_pkg.sv
design/tcg_serial_div.sv
design/tcg_breath_rom.sv
design/timed_curve_generator.sv
design/tcg_checker.sv
tb/sv/tb_timed_curve_generator.sv
